/* hw/rtl/ncdf_pkg.sv */
// Shared constants, beat type and coefficient tables for the normal CDF pipeline.
// Depends on nothing; every other file of the block refers to it by scoped names.
package ncdf_pkg;

   localparam int IN_FRAC  = 12;               // fraction bits of z
   localparam int OUT_FRAC = 16;               // fraction bits of the probability
   localparam int Z_W      = 16;
   localparam int P_W      = OUT_FRAC + 1;
   localparam int QBITS    = 30;               // internal Q30 format

   localparam int X_W      = 34;               // Horner accumulator, covers +/-8.0
   localparam int OP_W     = 33;               // multiplier operand, covers +/-4.0
   localparam int PROD_W   = X_W + OP_W;

   localparam int SMALL_TERMS   = 9;
   localparam int MID_TERMS     = 15;
   localparam int HORNER_STAGES = MID_TERMS - 1;
   localparam int SCALE_STAGE   = SMALL_TERMS;  // small range: multiply by 2y here

   localparam int Y_SHIFT  = QBITS - 1 - IN_FRAC;       // |z| to y in Q30
   localparam int W_SHIFT  = 2 * Y_SHIFT - QBITS;       // y*y is exact in this range
   localparam int SQ_W     = IN_FRAC + 1;               // |z| below 2.0 fits here

   localparam logic [Z_W-1:0] LARGE_MAG = Z_W'(6 << IN_FRAC);
   localparam logic [Z_W-1:0] SMALL_MAG = Z_W'(2 << IN_FRAC);

   localparam logic signed [OP_W-1:0] ONE_Q = OP_W'(64'sd1 << QBITS);
   localparam logic signed [OP_W-1:0] TWO_Q = OP_W'(64'sd2 << QBITS);

   localparam logic [P_W-1:0] HALF_P = P_W'(1 << (OUT_FRAC - 1));
   localparam logic [P_W-1:0] ONE_P  = P_W'(1 << OUT_FRAC);

   typedef enum logic [2:0] {
      PH_POLY  = 3'b001,
      PH_SCALE = 3'b010,
      PH_PASS  = 3'b100
   } phase_type;

   typedef struct packed {
      logic                   small_range;
      logic                   positive;
      logic                   special;
      logic [P_W-1:0]         special_prob;
      logic signed [OP_W-1:0] op;           // w for the small range, t otherwise
      logic signed [OP_W-1:0] y2;           // 2y, used once in the small range
      logic signed [X_W-1:0]  x;
   } beat_type;

   // Coefficient given in units of 1e-12, rounded to Q30 with ties upward.
   function automatic logic signed [X_W-1:0] coef_q30(input bit neg, input longint n);
      longint v;
      v = (n * 64'sd262144 + 64'sd122070312) / 64'sd244140625;
      if (neg) v = -v;
      return X_W'(v);
   endfunction

   localparam logic signed [X_W-1:0] SMALL_COEF [SMALL_TERMS] = '{
      coef_q30(1'b0, 64'sd124818987),    coef_q30(1'b1, 64'sd1075204047),
      coef_q30(1'b0, 64'sd5198775019),   coef_q30(1'b1, 64'sd19198292004),
      coef_q30(1'b0, 64'sd59054035642),  coef_q30(1'b1, 64'sd151968751364),
      coef_q30(1'b0, 64'sd319152932694), coef_q30(1'b1, 64'sd531923007300),
      coef_q30(1'b0, 64'sd797884560593)
   };

   localparam logic signed [X_W-1:0] MID_COEF [MID_TERMS] = '{
      coef_q30(1'b1, 64'sd45255659),     coef_q30(1'b0, 64'sd152529290),
      coef_q30(1'b1, 64'sd19538132),     coef_q30(1'b1, 64'sd676904986),
      coef_q30(1'b0, 64'sd1390604284),   coef_q30(1'b1, 64'sd794620820),
      coef_q30(1'b1, 64'sd2034254874),   coef_q30(1'b0, 64'sd6549791214),
      coef_q30(1'b1, 64'sd10557625006),  coef_q30(1'b0, 64'sd11630447319),
      coef_q30(1'b1, 64'sd9279453341),   coef_q30(1'b0, 64'sd5353579108),
      coef_q30(1'b1, 64'sd2141268741),   coef_q30(1'b0, 64'sd535310849),
      coef_q30(1'b0, 64'sd999936657524)
   };

   // What the small range does in Horner stage k (1-based).
   function automatic phase_type stage_phase(input int k);
      if (k < SCALE_STAGE)       return PH_POLY;
      else if (k == SCALE_STAGE) return PH_SCALE;
      else                       return PH_PASS;
   endfunction

   function automatic logic signed [X_W-1:0] stage_small_coef(input int k);
      if (k < SMALL_TERMS) return SMALL_COEF[4'(k)];
      else                 return '0;
   endfunction

endpackage

/* hw/rtl/ncdf_front.sv */
// Entry stage: magnitude, range decode, Horner operand and starting coefficient.
// Depends on ncdf_pkg.
module ncdf_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [ncdf_pkg::Z_W-1:0] in_z,
   output logic                           out_valid,
   input  logic                           out_ready,
   output ncdf_pkg::beat_type             out_beat
);

   logic                                valid_ff;
   ncdf_pkg::beat_type                  beat_ff, beat_in;
   logic [ncdf_pkg::Z_W-1:0]            mag;
   logic                                zero, saturate, neg;
   logic signed [ncdf_pkg::OP_W-1:0]    y;
   logic [2*ncdf_pkg::SQ_W-1:0]         msq;
   logic signed [ncdf_pkg::OP_W-1:0]    w;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_comb begin
      neg   = in_z[ncdf_pkg::Z_W-1];
      // most negative z wraps to its unsigned magnitude
      mag   = neg ? ncdf_pkg::Z_W'(~in_z + 1'b1) : ncdf_pkg::Z_W'(in_z);
      zero  = (in_z == '0);
      saturate = (mag >= ncdf_pkg::LARGE_MAG);
      y     = ncdf_pkg::OP_W'(mag) <<< ncdf_pkg::Y_SHIFT;
      msq   = mag[ncdf_pkg::SQ_W-1:0] * mag[ncdf_pkg::SQ_W-1:0];
      w     = ncdf_pkg::OP_W'(msq) <<< ncdf_pkg::W_SHIFT;

      beat_in.small_range  = (mag < ncdf_pkg::SMALL_MAG);
      beat_in.positive     = !neg && !zero;
      beat_in.special      = zero || saturate;
      beat_in.special_prob = zero ? ncdf_pkg::HALF_P :
                             (!neg ? ncdf_pkg::ONE_P : '0);
      beat_in.op           = beat_in.small_range ? w : (y - ncdf_pkg::TWO_Q);
      beat_in.y2           = y <<< 1;
      beat_in.x            = beat_in.small_range ? ncdf_pkg::SMALL_COEF[0]
                                                 : ncdf_pkg::MID_COEF[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         beat_ff <= beat_in;
      end
   end

endmodule

/* hw/rtl/ncdf_horner.sv */
// One Horner step: x <= round(x * operand) + coefficient, Q30, ties away from zero.
// Depends on ncdf_pkg; the top level ties phase and coefficients per stage.
module ncdf_horner (
   input  logic                              clock,
   input  logic                              reset,
   input  ncdf_pkg::phase_type               phase,
   input  logic signed [ncdf_pkg::X_W-1:0]   small_coef,
   input  logic signed [ncdf_pkg::X_W-1:0]   mid_coef,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  ncdf_pkg::beat_type                in_beat,
   output logic                              out_valid,
   input  logic                              out_ready,
   output ncdf_pkg::beat_type                out_beat
);

   localparam logic signed [ncdf_pkg::PROD_W-1:0] HALF_LSB =
      ncdf_pkg::PROD_W'(64'sd1 << (ncdf_pkg::QBITS - 1));

   logic                                  valid_ff;
   ncdf_pkg::beat_type                    beat_ff, beat_in;
   logic signed [ncdf_pkg::OP_W-1:0]      operand;
   logic signed [ncdf_pkg::X_W-1:0]       coef;
   logic signed [ncdf_pkg::PROD_W-1:0]    prod, rnd;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_comb begin
      operand = in_beat.op;
      coef    = mid_coef;
      if (in_beat.small_range) begin
         coef = small_coef;
         case (phase)
            ncdf_pkg::PH_POLY:  operand = in_beat.op;
            ncdf_pkg::PH_SCALE: operand = in_beat.y2;
            ncdf_pkg::PH_PASS:  operand = ncdf_pkg::ONE_Q;   // hold x unchanged
            default:            operand = ncdf_pkg::ONE_Q;
         endcase
      end
      prod = in_beat.x * operand;
      // negative products round half away from zero with one LSB less of bias
      rnd  = prod + (prod[ncdf_pkg::PROD_W-1] ? HALF_LSB - 1 : HALF_LSB);
      beat_in   = in_beat;
      beat_in.x = $signed(rnd[ncdf_pkg::QBITS +: ncdf_pkg::X_W]) + coef;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         beat_ff <= beat_in;
      end
   end

endmodule

/* hw/rtl/ncdf_back.sv */
// Output stage: 0.5 +/- x/2 in Q31, clamp to [0, 1], round to the output format.
// Depends on ncdf_pkg; drives the result channel register.
module ncdf_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  ncdf_pkg::beat_type           in_beat,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [ncdf_pkg::P_W-1:0]     out_prob
);

   localparam int R_W  = ncdf_pkg::X_W + 2;
   localparam int RC_W = ncdf_pkg::QBITS + 2;
   localparam int RSH  = ncdf_pkg::QBITS + 1 - ncdf_pkg::OUT_FRAC;

   localparam logic signed [R_W-1:0] ONE_R = R_W'(64'sd1 << ncdf_pkg::QBITS);
   localparam logic signed [R_W-1:0] TOP_R = R_W'(64'sd2 << ncdf_pkg::QBITS);
   localparam logic [RC_W-1:0] RND_BIAS = RC_W'(64'sd1 << (RSH - 1));

   logic                        valid_ff;
   logic [ncdf_pkg::P_W-1:0]    prob_ff, prob_in;
   logic signed [R_W-1:0]       xe, r;
   logic [RC_W-1:0]             rc, rs;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_prob  = prob_ff;

   always_comb begin
      xe = R_W'(in_beat.x);
      r  = in_beat.positive ? ONE_R + xe : ONE_R - xe;
      if (r < 0)          rc = '0;
      else if (r > TOP_R) rc = RC_W'(TOP_R);
      else                rc = RC_W'(r);
      rs = rc + RND_BIAS;
      prob_in = in_beat.special ? in_beat.special_prob : rs[RSH +: ncdf_pkg::P_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prob_ff <= prob_in;
      end
   end

endmodule

/* hw/rtl/normal_cdf_polynomial.sv */
// Standard normal CDF of a Q3.12 deviate z, returned with 16 fraction bits (65536 is 1.0).
// The block is a fully pipelined evaluator: it accepts one deviate every clock while the
// result side keeps up. It is built from one entry stage, fourteen Horner stages of one
// 34x33 multiply each (the fifteen-term polynomial for |z| from 2 to 6; the nine-term
// polynomial for |z| below 2 uses the same stages, then scales by 2y and passes through),
// and one output register.
// Every stage has its own valid bit and takes a new beat whenever it is empty or its
// content moves on, so bubbles close up during a stall. z = 0 gives exactly 0.5;
// |z| of 6.0 or more gives 1.0 for positive z and 0 for negative z.
// Depends on ncdf_pkg, ncdf_front, ncdf_horner and ncdf_back.
module normal_cdf_polynomial (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [ncdf_pkg::Z_W-1:0] req_z_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ncdf_pkg::P_W-1:0]        rsp_probability
);

   localparam int N = ncdf_pkg::HORNER_STAGES;

   logic               vld [N+1];
   logic               rdy [N+1];
   ncdf_pkg::beat_type beat [N+1];

   ncdf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_z      (req_z_value),
      .out_valid (vld[0]),
      .out_ready (rdy[0]),
      .out_beat  (beat[0])
   );

   for (genvar k = 1; k <= N; k++) begin : g_stage
      ncdf_horner u_stage (
         .clock      (clock),
         .reset      (reset),
         .phase      (ncdf_pkg::stage_phase(k)),
         .small_coef (ncdf_pkg::stage_small_coef(k)),
         .mid_coef   (ncdf_pkg::MID_COEF[k]),
         .in_valid   (vld[k-1]),
         .in_ready   (rdy[k-1]),
         .in_beat    (beat[k-1]),
         .out_valid  (vld[k]),
         .out_ready  (rdy[k]),
         .out_beat   (beat[k])
      );
   end

   ncdf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld[N]),
      .in_ready  (rdy[N]),
      .in_beat   (beat[N]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_prob  (rsp_probability)
   );

`ifndef SYNTH
   // an empty output register frees every stage, so the input must be open
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while the result register is empty");

   a_prob_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_probability <= ncdf_pkg::ONE_P)
      else $error("probability above one");

   a_special_code: assert property (@(posedge clock) disable iff (reset)
      vld[N] && beat[N].special |->
         beat[N].special_prob == ncdf_pkg::HALF_P ||
         (beat[N].positive && beat[N].special_prob == ncdf_pkg::ONE_P) ||
         (!beat[N].positive && beat[N].special_prob == '0))
      else $error("special-case result does not match the deviate sign");

   a_stall_holds_last: assert property (@(posedge clock) disable iff (reset)
      vld[N] && !rdy[N] |=> vld[N] && $stable(beat[N].x))
      else $error("last Horner stage changed while stalled");
`endif

endmodule

/* sim/testbench.sv */
// Self-checking testbench for normal_cdf_polynomial: bursty deviates in, stalled probabilities out.
// Expected probabilities come from a fixed-point Horner model held here; needs ncdf_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int RANDOM_DEVIATES = 650;
   localparam int DRAIN_CYCLES    = 40;
   localparam longint Q30_ONE     = 64'sd1 << 30;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic signed [ncdf_pkg::Z_W-1:0] req_z_value = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [ncdf_pkg::P_W-1:0]        rsp_probability;

   logic signed [ncdf_pkg::Z_W-1:0] z_pending [$];
   logic [ncdf_pkg::P_W-1:0]        expected_prob [$];
   int                    error_count = 0;
   int                    burst_left = 1;
   int                    gap_left = 0;
   int                    stall_cycle = 0;
   int                    stall_mode = 0;

   normal_cdf_polynomial u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_z_value     (req_z_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_probability (rsp_probability)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Coefficients in units of 1e-12, highest power first.
   function automatic longint erf_small_pico(input int k);
      case (k)
         0: return  64'sd124818987;
         1: return -64'sd1075204047;
         2: return  64'sd5198775019;
         3: return -64'sd19198292004;
         4: return  64'sd59054035642;
         5: return -64'sd151968751364;
         6: return  64'sd319152932694;
         7: return -64'sd531923007300;
         default: return 64'sd797884560593;
      endcase
   endfunction

   function automatic longint erf_mid_pico(input int k);
      case (k)
         0:  return -64'sd45255659;
         1:  return  64'sd152529290;
         2:  return -64'sd19538132;
         3:  return -64'sd676904986;
         4:  return  64'sd1390604284;
         5:  return -64'sd794620820;
         6:  return -64'sd2034254874;
         7:  return  64'sd6549791214;
         8:  return -64'sd10557625006;
         9:  return  64'sd11630447319;
         10: return -64'sd9279453341;
         11: return  64'sd5353579108;
         12: return -64'sd2141268741;
         13: return  64'sd535310849;
         default: return 64'sd999936657524;
      endcase
   endfunction

   // Round the magnitude to Q30 with ties upward, then restore the sign.
   function automatic longint pico_to_q30(input longint pico);
      longint m;
      m = (pico < 0) ? -pico : pico;
      m = (m * 64'sd262144 + 64'sd122070312) / 64'sd244140625;
      return (pico < 0) ? -m : m;
   endfunction

   function automatic longint q30_mul(input longint a, input longint b);
      longint          p;
      longint unsigned m;
      p = a * b;
      m = (p < 0) ? longint'(0) - p : p;
      m = (m + (64'd1 << 29)) >> 30;
      return (p < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [ncdf_pkg::P_W-1:0] cdf_of_deviate(
      input logic signed [ncdf_pkg::Z_W-1:0] z);
      longint          mag, y, w, t, x, r;
      longint unsigned p;
      if (z == 0) return ncdf_pkg::HALF_P;
      mag = (z < 0) ? -longint'(z) : longint'(z);
      if (mag >= (64'sd6 << ncdf_pkg::IN_FRAC)) return (z > 0) ? ncdf_pkg::ONE_P : '0;
      y = mag << (ncdf_pkg::QBITS - 1 - ncdf_pkg::IN_FRAC);
      if (mag < (64'sd2 << ncdf_pkg::IN_FRAC)) begin
         w = q30_mul(y, y);
         x = pico_to_q30(erf_small_pico(0));
         for (int i = 1; i < 9; i++) x = q30_mul(x, w) + pico_to_q30(erf_small_pico(i));
         x = q30_mul(x, 2 * y);
      end else begin
         t = y - 2 * Q30_ONE;
         x = pico_to_q30(erf_mid_pico(0));
         for (int i = 1; i < 15; i++) x = q30_mul(x, t) + pico_to_q30(erf_mid_pico(i));
      end
      // 0.5 +/- x/2 in Q31, clamp into [0, 1]
      r = (z > 0) ? Q30_ONE + x : Q30_ONE - x;
      if (r < 0) r = 0;
      if (r > 2 * Q30_ONE) r = 2 * Q30_ONE;
      p = (longint'(r) + (64'd1 << (ncdf_pkg::QBITS - ncdf_pkg::OUT_FRAC)))
          >> (ncdf_pkg::QBITS + 1 - ncdf_pkg::OUT_FRAC);
      return p[ncdf_pkg::P_W-1:0];
   endfunction

   // Stimulus: directed corners first, then mostly in-range deviates.
   initial begin
      int sel;
      int mag;
      logic signed [ncdf_pkg::Z_W-1:0] z_draw;
      z_pending = '{16'sd0, 16'sd1, -16'sd1, 16'sd2, -16'sd2, 16'sd4096, -16'sd4096,
                    16'sd8191, -16'sd8191, 16'sd8192, -16'sd8192, 16'sd8193, -16'sd8193,
                    16'sd16384, -16'sd16384, 16'sd24575, -16'sd24575, 16'sd24576,
                    -16'sd24576, 16'sd32767, 16'sh8000, 16'sh5555, 16'shAAAA,
                    16'sd20000, -16'sd20000};
      for (int n = 0; n < RANDOM_DEVIATES; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 2)       mag = 0;
         else if (sel < 42) mag = $urandom_range(1, 8191);
         else if (sel < 77) mag = $urandom_range(8192, 24575);
         else if (sel < 89) mag = $urandom_range(24576, 32767);
         else               mag = -1;
         if (mag < 0) z_draw = ncdf_pkg::Z_W'($urandom);
         else         z_draw = ncdf_pkg::Z_W'($urandom_range(0, 1) ? -mag : mag);
         z_pending.push_back(z_draw);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: bursts of beats separated by random gaps; record each accepted beat.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= $urandom_range(1, 40);
         gap_left   <= 0;
      end else begin
         if (req_valid && req_ready) expected_prob.push_back(cdf_of_deviate(req_z_value));
         if (!req_valid || req_ready) begin
            if (gap_left > 0 || z_pending.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
               req_valid   <= 1'b1;
               req_z_value <= z_pending.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // Receiver back-pressure: switch at random among four stall patterns.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_cycle <= 0;
         stall_mode  <= 0;
      end else begin
         stall_cycle <= stall_cycle + 1;
         if (stall_cycle % 128 == 127) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 99) >= 30);
            2: rsp_ready <= ($urandom_range(0, 99) >= 85);
            default: rsp_ready <= (stall_cycle % 16 < 11);
         endcase
      end
   end

   // Monitor: compare each probability beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_prob.size() == 0) begin
            $error("probability: expected none, actual %0d", rsp_probability);
            error_count++;
         end else begin
            if (rsp_probability !== expected_prob[0]) begin
               $error("probability: expected %0d, actual %0d", expected_prob[0],
                      rsp_probability);
               error_count++;
            end
            void'(expected_prob.pop_front());
         end
      end
   end

   initial begin
      @(negedge reset);
      do @(posedge clock);
      while (z_pending.size() != 0 || req_valid || expected_prob.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_prob.size() != 0) begin
         $error("probability: %0d expected beats never arrived", expected_prob.size());
         error_count++;
      end
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #400000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/ncdf_pkg.sv
hw/rtl/ncdf_front.sv
hw/rtl/ncdf_horner.sv
hw/rtl/ncdf_back.sv
hw/rtl/normal_cdf_polynomial.sv
sim/testbench.sv
